// File: rtl/core/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and reset values of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Fixed field widths of the request, response and register ports
   localparam int COUNT_W  = 11;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Block count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

endpackage : bba_pkg
`default_nettype wire

// File: rtl/core/bitmap_block_allocator_unit.sv
`default_nettype none
// Allocate: reads 1 to MAX_BLOCKS/WORD_BITS (rounded up) map words, one word per cycle
//   through the map RAM, then gives the rsp_valid strobe.
// Free: word walk to word block_index/WORD_BITS, one RAM read, write back;
//   an out-of-range free or an allocate at zero count answers straight from idle.
// New items start in idle, as early as the rsp_valid strobe; results are not stalled.
// Reset: busy while the MAX_BLOCKS/WORD_BITS (rounded up) map words are cleared.
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit bitmap block allocator: map words in a synchronous RAM, scanned
// and updated by a read-modify-write sequencer, block count register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
   parameter int MAX_BLOCKS = 1024,
   parameter int WORD_BITS  = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_opcode,
   input  wire logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   output logic                               rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]        rsp_result_block,
   output logic [bba_pkg::STATUS_W-1:0]       rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bba_pkg::COUNT_W-1:0]   csr_block_count
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W     = (CNT_W > bba_pkg::COUNT_W) ? CNT_W : bba_pkg::COUNT_W;

   logic [bba_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0]            count_ext;
   logic [CNT_W-1:0]            limit;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [WORD_BITS-1:0]        wr_data;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [WORD_BITS-1:0]        rd_data;

   // Block count register, written while idle
   assign csr_ready = !busy;
   assign count_in  = (csr_valid && csr_ready) ? csr_block_count : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= bba_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // Saturate the count to the map size
   assign count_ext = CMP_W'(count_ff);
   assign limit     = (count_ext > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                       : CNT_W'(count_ext);

   bba_map_ram #(
      .DEPTH  (MAP_WORDS),
      .WIDTH  (WORD_BITS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bba_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS),
      .MAP_WORDS  (MAP_WORDS),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_block_index  (req_block_index),
      .limit            (limit),
      .rsp_valid        (rsp_valid),
      .rsp_result_block (rsp_result_block),
      .rsp_status       (rsp_status),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

endmodule : bitmap_block_allocator_unit
`default_nettype wire

// File: rtl/core/bba_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_map_ram
// Single-write, single-read synchronous memory holding the usage map words.
// Read data is registered and arrives in the cycle after the read request.
// ----------------------------------------------------------------------------
module bba_map_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bba_map_ram
`default_nettype wire

// File: rtl/core/bba_word_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_word_scan
// Priority encoder over one map word: finds the lowest clear bit among the
// bits that still lie below the block count.
// ----------------------------------------------------------------------------
module bba_word_scan #(
   parameter int WORD_BITS = 32,
   parameter int CNT_W     = 11
) (
   input  wire logic [WORD_BITS-1:0]         word,
   input  wire logic [CNT_W-1:0]             remain,
   output logic                              found,
   output logic [$clog2(WORD_BITS)-1:0]      bit_pos
);

   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int SW    = (CNT_W > BIT_W + 1) ? CNT_W : BIT_W + 1;

   logic [WORD_BITS-1:0] free_bits;

   // Keep only clear bits whose block number is below the count
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_bits[b] = !word[b] && (SW'(b) < SW'(remain));
      end
   end

   // Pick the lowest free bit
   always_comb begin
      found   = 1'b0;
      bit_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            found   = 1'b1;
            bit_pos = BIT_W'(b);
         end
      end
   end

endmodule : bba_word_scan
`default_nettype wire

// File: rtl/core/bba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: clears the map after reset, walks the map words for an
// allocate, locates and clears the word bit for a free, and drives the
// registered response strobe.
// ----------------------------------------------------------------------------
module bba_ctrl #(
   parameter int MAX_BLOCKS = 1024,
   parameter int WORD_BITS  = 32,
   parameter int MAP_WORDS  = 32,
   parameter int ADDR_W     = 5,
   parameter int CNT_W      = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_opcode,
   input  wire logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   input  wire logic [CNT_W-1:0]              limit,
   output logic                               rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]        rsp_result_block,
   output logic [bba_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               wr_en,
   output logic [ADDR_W-1:0]                  wr_addr,
   output logic [WORD_BITS-1:0]               wr_data,
   output logic                               rd_en,
   output logic [ADDR_W-1:0]                  rd_addr,
   input  wire logic [WORD_BITS-1:0]          rd_data
);

   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int BLK_W = $clog2(MAX_BLOCKS);
   localparam int SW    = (CNT_W > BIT_W + 1) ? CNT_W : BIT_W + 1;
   localparam int IW    = (CNT_W > bba_pkg::INDEX_W) ? CNT_W : bba_pkg::INDEX_W;
   localparam int SUM_W = ((BLK_W > BIT_W) ? BLK_W : BIT_W) + 1;

   typedef enum logic [4:0] {
      ST_WIPE   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_LOCATE = 5'b01000,
      ST_CLEAR  = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [ADDR_W-1:0]              word_ff, word_in;
   logic [BLK_W-1:0]               base_ff, base_in;
   logic [CNT_W-1:0]               rem_ff, rem_in;
   logic [BIT_W-1:0]               bit_ff, bit_in;
   logic [bba_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::INDEX_W-1:0]    rsp_block_ff, rsp_block_in;
   logic [bba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                           scan_found;
   logic [BIT_W-1:0]               scan_bit;
   logic [SUM_W-1:0]               scan_block;
   logic                           in_range;
   logic                           last_word;
   logic [WORD_BITS-1:0]           set_mask;
   logic [WORD_BITS-1:0]           clr_mask;

   bba_word_scan #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W)
   ) u_scan (
      .word    (rd_data),
      .remain  (rem_ff),
      .found   (scan_found),
      .bit_pos (scan_bit)
   );

   // Block number of the found bit, and single-bit masks
   assign scan_block = SUM_W'(base_ff) + SUM_W'(scan_bit);
   assign set_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << scan_bit;
   assign clr_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff;
   assign in_range   = IW'(req_block_index) < IW'(limit);
   assign last_word  = SW'(rem_ff) <= SW'(WORD_BITS);

   // Next state, memory access and response
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = word_ff;

      unique case (state_ff)
         ST_WIPE: begin
            wr_en   = 1'b1;
            word_in = word_ff + 1'b1;
            if (word_ff == ADDR_W'(MAP_WORDS - 1)) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               idx_in = req_block_index;
               if (req_opcode == bba_pkg::OP_ALLOC) begin
                  if (limit == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = bba_pkg::STATUS_FULL;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     word_in  = '0;
                     base_in  = '0;
                     rem_in   = limit;
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (in_range) begin
                     rem_in   = CNT_W'(req_block_index);
                     word_in  = '0;
                     state_in = ST_LOCATE;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = bba_pkg::STATUS_RANGE;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_found) begin
               // Mark the block used and report it
               wr_en         = 1'b1;
               wr_data       = rd_data | set_mask;
               rsp_valid_in  = 1'b1;
               rsp_block_in  = bba_pkg::INDEX_W'(scan_block);
               rsp_status_in = bba_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end else if (last_word) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = '0;
               rsp_status_in = bba_pkg::STATUS_FULL;
               state_in      = ST_IDLE;
            end else begin
               // Advance to the next word, read issued now
               rem_in  = rem_ff - CNT_W'(WORD_BITS);
               base_in = base_ff + BLK_W'(WORD_BITS);
               word_in = word_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = word_ff + 1'b1;
            end
         end
         ST_LOCATE: begin
            if (SW'(rem_ff) < SW'(WORD_BITS)) begin
               rd_en    = 1'b1;
               bit_in   = BIT_W'(rem_ff);
               state_in = ST_CLEAR;
            end else begin
               rem_in  = rem_ff - CNT_W'(WORD_BITS);
               word_in = word_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            // Drop the block's bit and report it
            wr_en         = 1'b1;
            wr_data       = rd_data & ~clr_mask;
            rsp_valid_in  = 1'b1;
            rsp_block_in  = idx_ff;
            rsp_status_in = bba_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      idx_ff        <= idx_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_status       = rsp_status_ff;

endmodule : bba_ctrl
`default_nettype wire
